@@ rtl/core/bitmap_extent_page_allocator_defines.svh @@
// Assertion helpers for the page allocator
`ifndef BITMAP_EXTENT_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_EXTENT_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BEP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, checked outside reset
`define BEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/core/bep_pkg.sv @@
package bep_pkg;

  localparam int MAX_PAGES = 4096;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int IDX_W     = PAGE_W + 2;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ROWS      = MAX_PAGES / WORD_W;
  localparam int ROW_W     = PAGE_W - BIT_W;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_FORMAT = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_NONE     = 2'd2,
    ST_CAPACITY = 2'd3
  } status_t;

  localparam logic [0:0] REG_RESERVED = 1'b0;
  localparam logic [0:0] REG_EXISTING = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT,
    S_AHEAD,
    S_ALINK,
    S_RECOUNT,
    S_SCAN,
    S_TAKE,
    S_FREE,
    S_LOAD,
    S_LOADW,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/bep_ram.sv @@
module bep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/bitmap_extent_page_allocator.sv @@
// Page store allocator: allocation bitmap, LIFO free list, free-page counter.
// Request channel: mode/start_page/page_count transfer when start is high and
// busy is low. busy stays high until the result has been shown.
// Result channel: page_index, page_valid, status, grown_pages, free_pages and
// total_pages are valid for the single cycle in which done is high; there is
// no back-pressure, the receiver must take the transfer in that cycle.
// Config: cfg_we writes cfg_data to register cfg_index (0 reserved_pages,
// 1 existing_pages); write only while busy is low.
// Flow: one request at a time. The bitmap sits in a 64-bit-wide RAM and is
// walked one page per cycle through a one-word cache, pausing at each row
// change to write back the cached row when dirty and fetch the wanted one.
// A zero count or unused mode 3 goes straight to done; format marks the first
// reserved_pages pages; a single-page allocate pops the free list when it is
// not empty; a free walks its pages; an allocate runs up to one recount plus
// two first-fit scans of page_total pages and the take of page_count pages.
// Reset: bitmap row valid bits clear (every page free), list empty, counters 0,
// registers 3 and 0. No clearing pass is needed.
module bitmap_extent_page_allocator
  import bep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic [1:0]        mode,
  input  logic [PAGE_W-1:0] start_page,
  input  logic [CNT_W-1:0]  page_count,
  output logic [PAGE_W-1:0] page_index,
  output logic              page_valid,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  grown_pages,
  output logic [CNT_W-1:0]  free_pages,
  output logic [CNT_W-1:0]  total_pages,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_data
);

  `include "bitmap_extent_page_allocator_defines.svh"

  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_PAGES);
  localparam logic [IDX_W-1:0] MAXI = IDX_W'(MAX_PAGES);

  state_t            state, state_next, ret, ret_next;
  logic [CNT_W-1:0]  reserved_pages, existing_pages;
  logic [CNT_W-1:0]  list_head, list_head_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic [CNT_W-1:0]  page_total, page_total_next;
  logic [ROWS-1:0]   vld, vld_next;
  logic [WORD_W-1:0] cw, cw_next;
  logic [ROW_W-1:0]  cw_row, cw_row_next;
  logic              loaded, loaded_next, dirty, dirty_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic [CNT_W-1:0]  req_count, req_count_next;
  logic [CNT_W-1:0]  limit, limit_next;
  logic [CNT_W-1:0]  run_len, run_len_next;
  logic [PAGE_W-1:0] run_base, run_base_next;
  logic              second, second_next, any, any_next;
  logic [PAGE_W-1:0] page_index_next;
  logic              page_valid_next;
  logic [1:0]        status_next;
  logic [CNT_W-1:0]  grown_pages_next;

  logic              b_we, b_re;
  logic [ROW_W-1:0]  b_waddr, b_raddr;
  logic [WORD_W-1:0] b_wdata, b_rdata;
  logic              l_we, l_re;
  logic [PAGE_W-1:0] l_waddr, l_raddr;
  logic [CNT_W-1:0]  l_wdata, l_rdata;

  logic [ROW_W-1:0]  idx_row;
  logic [BIT_W-1:0]  idx_bit;
  logic              hit, cur_bit;

  assign idx_row = idx[PAGE_W-1:BIT_W];
  assign idx_bit = idx[BIT_W-1:0];
  assign hit     = loaded && (cw_row == idx_row);
  assign cur_bit = cw[idx_bit];

  function automatic logic [CNT_W-1:0] add_free(input logic [CNT_W-1:0] f,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] room;
    room = MAXC - f;
    return (n >= room) ? MAXC : f + n;
  endfunction

  bep_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_bitmap (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  bep_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PAGES)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ret            <= S_IDLE;
      reserved_pages <= CNT_W'(3);
      existing_pages <= '0;
      list_head      <= MAXC;
      free_count     <= '0;
      page_total     <= '0;
      vld            <= '0;
      loaded         <= 1'b0;
      dirty          <= 1'b0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      list_head  <= list_head_next;
      free_count <= free_count_next;
      page_total <= page_total_next;
      vld        <= vld_next;
      loaded     <= loaded_next;
      dirty      <= dirty_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RESERVED: reserved_pages <= cfg_data;
          REG_EXISTING: existing_pages <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cw          <= cw_next;
    cw_row      <= cw_row_next;
    idx         <= idx_next;
    rem         <= rem_next;
    req_count   <= req_count_next;
    limit       <= limit_next;
    run_len     <= run_len_next;
    run_base    <= run_base_next;
    second      <= second_next;
    any         <= any_next;
    page_index  <= page_index_next;
    page_valid  <= page_valid_next;
    status      <= status_next;
    grown_pages <= grown_pages_next;
  end

  always_comb begin
    logic [CNT_W-1:0] tot;
    state_next       = state;
    ret_next         = ret;
    list_head_next   = list_head;
    free_count_next  = free_count;
    page_total_next  = page_total;
    vld_next         = vld;
    cw_next          = cw;
    cw_row_next      = cw_row;
    loaded_next      = loaded;
    dirty_next       = dirty;
    idx_next         = idx;
    rem_next         = rem;
    req_count_next   = req_count;
    limit_next       = limit;
    run_len_next     = run_len;
    run_base_next    = run_base;
    second_next      = second;
    any_next         = any;
    page_index_next  = page_index;
    page_valid_next  = page_valid;
    status_next      = status;
    grown_pages_next = grown_pages;
    b_we    = 1'b0;
    b_waddr = cw_row;
    b_wdata = cw;
    b_re    = 1'b0;
    b_raddr = idx_row;
    l_we    = 1'b0;
    l_waddr = idx[PAGE_W-1:0];
    l_wdata = list_head;
    l_re    = 1'b0;
    l_raddr = idx[PAGE_W-1:0];
    tot     = (reserved_pages > existing_pages) ? reserved_pages : existing_pages;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          page_index_next  = '0;
          page_valid_next  = 1'b0;
          status_next      = ST_OK;
          grown_pages_next = '0;
          req_count_next   = page_count;
          run_len_next     = '0;
          run_base_next    = '0;
          second_next      = 1'b0;
          any_next         = 1'b0;
          state_next       = S_DONE;
          case (mode)
            MODE_FORMAT: begin
              vld_next   = '0;
              loaded_next = 1'b0;
              dirty_next = 1'b0;
              idx_next   = '0;
              limit_next = (reserved_pages > MAXC) ? MAXC : reserved_pages;
              page_total_next = (tot > MAXC) ? MAXC : tot;
              list_head_next  = MAXC;
              free_count_next = '0;
              state_next = S_FMT;
            end
            MODE_ALLOC: begin
              if (page_count == '0) begin
                status_next = ST_ZERO;
              end else if (page_count == CNT_W'(1) && list_head < MAXC) begin
                idx_next   = IDX_W'(list_head);
                state_next = S_AHEAD;
              end else begin
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            MODE_FREE: begin
              if (page_count == '0) begin
                status_next = ST_ZERO;
              end else begin
                idx_next   = IDX_W'(start_page);
                rem_next   = page_count;
                state_next = S_FREE;
              end
            end
            default: ;
          endcase
        end
      end
      S_FMT: begin
        if (idx < IDX_W'(limit)) begin
          if (!hit) begin
            ret_next = state; state_next = S_LOAD;
          end else begin
            cw_next[idx_bit] = 1'b1;
            dirty_next = 1'b1;
            idx_next = idx + IDX_W'(1);
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_AHEAD: begin
        if (!hit) begin
          ret_next = state; state_next = S_LOAD;
        end else if (cur_bit) begin
          // stale head: drop the list and recount
          list_head_next = MAXC;
          idx_next   = '0;
          rem_next   = '0;
          state_next = S_RECOUNT;
        end else begin
          cw_next[idx_bit] = 1'b1;
          dirty_next = 1'b1;
          l_re = 1'b1;
          free_count_next = (free_count != '0) ? free_count - CNT_W'(1) : free_count;
          page_index_next = idx[PAGE_W-1:0];
          page_valid_next = 1'b1;
          state_next = S_ALINK;
        end
      end
      S_ALINK: begin
        list_head_next = l_rdata;
        state_next = S_DONE;
      end
      S_RECOUNT: begin
        if (idx < IDX_W'(page_total)) begin
          if (!hit) begin
            ret_next = state; state_next = S_LOAD;
          end else begin
            if (!cur_bit) rem_next = rem + CNT_W'(1);
            idx_next = idx + IDX_W'(1);
          end
        end else begin
          free_count_next = rem;
          idx_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx < IDX_W'(page_total)) begin
          if (!hit) begin
            ret_next = state; state_next = S_LOAD;
          end else if (cur_bit) begin
            run_base_next = PAGE_W'(idx + IDX_W'(1));
            run_len_next  = '0;
            idx_next      = idx + IDX_W'(1);
          end else if (run_len + CNT_W'(1) >= req_count) begin
            idx_next        = IDX_W'(run_base);
            rem_next        = req_count;
            page_index_next = run_base;
            page_valid_next = 1'b1;
            state_next      = S_TAKE;
          end else begin
            run_len_next = run_len + CNT_W'(1);
            idx_next     = idx + IDX_W'(1);
          end
        end else if (second) begin
          state_next = S_DONE;
        end else if ({1'b0, page_total} + {1'b0, req_count} > MAXI) begin
          status_next = ST_CAPACITY;
          state_next  = S_DONE;
        end else begin
          page_total_next  = page_total + req_count;
          free_count_next  = add_free(free_count, req_count);
          grown_pages_next = req_count;
          second_next      = 1'b1;
          idx_next         = '0;
          run_len_next     = '0;
          run_base_next    = '0;
        end
      end
      S_TAKE: begin
        if (rem != '0 && idx < MAXI) begin
          if (!hit) begin
            ret_next = state; state_next = S_LOAD;
          end else begin
            if (!cur_bit && free_count != '0) free_count_next = free_count - CNT_W'(1);
            cw_next[idx_bit] = 1'b1;
            dirty_next = 1'b1;
            idx_next = idx + IDX_W'(1);
            rem_next = rem - CNT_W'(1);
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE: begin
        if (rem != '0 && idx < IDX_W'(page_total) && idx < MAXI) begin
          if (!hit) begin
            ret_next = state; state_next = S_LOAD;
          end else begin
            if (cur_bit) begin
              cw_next[idx_bit] = 1'b0;
              dirty_next = 1'b1;
              l_we = 1'b1;
              list_head_next  = CNT_W'(idx);
              free_count_next = add_free(free_count, CNT_W'(1));
              any_next = 1'b1;
            end
            idx_next = idx + IDX_W'(1);
            rem_next = rem - CNT_W'(1);
          end
        end else begin
          status_next = any ? ST_OK : ST_NONE;
          state_next  = S_DONE;
        end
      end
      S_LOAD: begin
        // write back the cached row if dirty, fetch the wanted one
        b_we = loaded && dirty;
        b_re = 1'b1;
        if (loaded && dirty) vld_next[cw_row] = 1'b1;
        dirty_next = 1'b0;
        state_next = S_LOADW;
      end
      S_LOADW: begin
        cw_next     = vld[idx_row] ? b_rdata : '0;
        cw_row_next = idx_row;
        loaded_next = 1'b1;
        state_next  = ret;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
  end

  assign free_pages  = free_count;
  assign total_pages = page_total;

  `BEP_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `BEP_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `BEP_ASSERT_NOW(a_free_bound, clk, rst, 1'b1, free_count <= MAXC && page_total <= MAXC)
  `BEP_ASSERT_NOW(a_valid_ok, clk, rst, done && page_valid, status == ST_OK)

endmodule

@@ test/tb_bitmap_extent_page_allocator.sv @@
module tb_bitmap_extent_page_allocator;
  import bep_pkg::*;

  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic              page_valid;
    logic [1:0]        status;
    logic [CNT_W-1:0]  grown_pages;
    logic [CNT_W-1:0]  free_pages;
    logic [CNT_W-1:0]  total_pages;
  } alloc_reply_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              done;
  logic [1:0]        mode;
  logic [PAGE_W-1:0] start_page;
  logic [CNT_W-1:0]  page_count;
  logic [PAGE_W-1:0] page_index;
  logic              page_valid;
  logic [1:0]        status;
  logic [CNT_W-1:0]  grown_pages;
  logic [CNT_W-1:0]  free_pages;
  logic [CNT_W-1:0]  total_pages;
  logic              cfg_we;
  logic [0:0]        cfg_index;
  logic [CNT_W-1:0]  cfg_data;

  // shadow of the page store
  bit                m_bitmap [MAX_PAGES];
  int unsigned       m_link   [MAX_PAGES];
  int unsigned       m_head;
  int unsigned       m_free;
  int unsigned       m_total;
  int unsigned       m_reserved;
  int unsigned       m_existing;

  alloc_reply_t      pending_replies[$];
  int                fail_count;

  bitmap_extent_page_allocator i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

  function automatic void free_dec();
    if (m_free > 0) m_free--;
  endfunction

  function automatic void free_add(int unsigned n);
    if (n >= MAX_PAGES - m_free) m_free = MAX_PAGES;
    else m_free += n;
  endfunction

  function automatic bit first_fit(int unsigned cnt, output int unsigned at);
    int unsigned run_at;
    int unsigned run_len;
    run_at = 0;
    run_len = 0;
    at = 0;
    for (int unsigned i = 0; i < m_total && i < MAX_PAGES; i++) begin
      if (m_bitmap[i]) begin
        run_at = i + 1;
        run_len = 0;
      end else begin
        run_len++;
        if (run_len >= cnt) begin
          at = run_at;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void claim_run(int unsigned at, int unsigned cnt);
    for (int unsigned i = 0; i < cnt && at + i < MAX_PAGES; i++) begin
      if (!m_bitmap[at + i]) free_dec();
      m_bitmap[at + i] = 1'b1;
    end
  endfunction

  function automatic alloc_reply_t predict_reply(logic [1:0] md, int unsigned sp,
                                                 int unsigned cnt);
    alloc_reply_t r;
    int unsigned  at;
    int unsigned  h;
    int unsigned  n;
    int unsigned  rs;
    bit           got;
    bit           any;
    r = '0;
    got = 1'b0;
    if (md == MODE_FORMAT) begin
      rs = (m_reserved > MAX_PAGES) ? MAX_PAGES : m_reserved;
      n = (m_reserved > m_existing) ? m_reserved : m_existing;
      if (n > MAX_PAGES) n = MAX_PAGES;
      foreach (m_bitmap[i]) m_bitmap[i] = (i < rs);
      m_total = n;
      m_head = MAX_PAGES;
      m_free = 0;
    end else if (md == MODE_ALLOC) begin
      if (cnt == 0) r.status = ST_ZERO;
      else begin
        if (cnt == 1 && m_head < MAX_PAGES) begin
          h = m_head;
          if (m_bitmap[h]) begin
            // stale head: drop the list and recount
            m_head = MAX_PAGES;
            n = 0;
            for (int unsigned i = 0; i < m_total && i < MAX_PAGES; i++)
              if (!m_bitmap[i]) n++;
            m_free = n;
          end else begin
            m_head = m_link[h];
            m_bitmap[h] = 1'b1;
            free_dec();
            r.page_index = PAGE_W'(h);
            r.page_valid = 1'b1;
            got = 1'b1;
          end
        end
        if (!got) begin
          if (first_fit(cnt, at)) begin
            claim_run(at, cnt);
            r.page_index = PAGE_W'(at);
            r.page_valid = 1'b1;
          end else if (m_total + cnt > MAX_PAGES) begin
            r.status = ST_CAPACITY;
          end else begin
            m_total += cnt;
            free_add(cnt);
            r.grown_pages = CNT_W'(cnt);
            if (first_fit(cnt, at)) begin
              claim_run(at, cnt);
              r.page_index = PAGE_W'(at);
              r.page_valid = 1'b1;
            end
          end
        end
      end
    end else if (md == MODE_FREE) begin
      if (cnt == 0) r.status = ST_ZERO;
      else begin
        any = 1'b0;
        for (int unsigned i = 0; i < cnt; i++) begin
          if (sp + i >= m_total || sp + i >= MAX_PAGES) break;
          if (m_bitmap[sp + i]) begin
            m_bitmap[sp + i] = 1'b0;
            m_link[sp + i] = m_head;
            m_head = sp + i;
            free_add(1);
            any = 1'b1;
          end
        end
        if (!any) r.status = ST_NONE;
      end
    end
    r.free_pages = CNT_W'(m_free);
    r.total_pages = CNT_W'(m_total);
    return r;
  endfunction

  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_request(logic [1:0] md, int unsigned sp, int unsigned cnt);
    idle_gap();
    start      <= 1'b1;
    mode       <= md;
    start_page <= PAGE_W'(sp);
    page_count <= CNT_W'(cnt);
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(predict_reply(md, sp & (MAX_PAGES - 1),
                                            cnt & (2 * MAX_PAGES - 1)));
    start <= 1'b0;
    // wait for the busy flag to drop before the next transfer
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned val);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CNT_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_RESERVED) m_reserved = val & (2 * MAX_PAGES - 1);
    else m_existing = val & (2 * MAX_PAGES - 1);
  endtask

  always @(posedge clk) begin
    alloc_reply_t e;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected result: actual idx=%0d", $time, page_index);
        fail_count++;
      end else begin
        e = pending_replies.pop_front();
        if (page_index !== e.page_index || page_valid !== e.page_valid ||
            status !== e.status || grown_pages !== e.grown_pages ||
            free_pages !== e.free_pages || total_pages !== e.total_pages) begin
          $display("%0t mismatch: expected idx=%0d v=%0d st=%0d g=%0d f=%0d t=%0d",
                   $time, e.page_index, e.page_valid, e.status, e.grown_pages,
                   e.free_pages, e.total_pages);
          $display("%0t           actual idx=%0d v=%0d st=%0d g=%0d f=%0d t=%0d",
                   $time, page_index, page_valid, status, grown_pages,
                   free_pages, total_pages);
          fail_count++;
        end
      end
    end
  end

  task automatic test_edges();
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_FREE, 0, 0);
    send_request(MODE_FREE, 5, 3);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_FORMAT, 0, 0);
    send_request(MODE_ALLOC, 0, 4);
    send_request(MODE_FREE, 4095, 4096);
    send_request(MODE_FREE, 3, 2);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_RSVD, 4095, 8191);
    send_request(MODE_ALLOC, 0, 4096);
    send_request(MODE_ALLOC, 0, 8191);
    send_request(MODE_FREE, 0, 8191);
  endtask

  task automatic test_stale_head();
    // free two pages, then reclaim both by a multi-page scan so the head goes stale
    send_request(MODE_FORMAT, 0, 0);
    send_request(MODE_ALLOC, 0, 6);
    send_request(MODE_FREE, 3, 2);
    send_request(MODE_ALLOC, 0, 2);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_FREE, 4, 1);
    send_request(MODE_ALLOC, 0, 4096);
    send_request(MODE_ALLOC, 0, 1);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_RESERVED, 4096);
    write_reg(REG_EXISTING, 4096);
    send_request(MODE_FORMAT, 0, 0);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_FREE, 4090, 10);
    send_request(MODE_ALLOC, 0, 1);
    write_reg(REG_RESERVED, 8191);
    write_reg(REG_EXISTING, 0);
    send_request(MODE_FORMAT, 0, 0);
    write_reg(REG_RESERVED, 1);
    write_reg(REG_EXISTING, 8191);
    send_request(MODE_FORMAT, 0, 0);
    send_request(MODE_ALLOC, 0, 1);
  endtask

  task automatic test_random(int unsigned items, int unsigned res, int unsigned ext);
    int unsigned k;
    int unsigned cnt;
    write_reg(REG_RESERVED, res);
    write_reg(REG_EXISTING, ext);
    send_request(MODE_FORMAT, 0, 0);
    for (int unsigned n = 0; n < items; n++) begin
      k = $urandom_range(0, 99);
      cnt = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
      if (k < 3) cnt = $urandom_range(0, 8191);
      if (k < 45)
        send_request(MODE_ALLOC, $urandom, cnt);
      else if (k < 85)
        send_request(MODE_FREE,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 200), cnt);
      else if (k < 88)
        send_request(MODE_FORMAT, $urandom, $urandom);
      else if (k < 90)
        send_request(MODE_RSVD, $urandom, $urandom);
      else
        send_request(MODE_ALLOC, $urandom, 1);
    end
  endtask

  initial begin
    fail_count = 0;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_ALLOC;
    start_page = '0;
    page_count = '0;
    cfg_we = 1'b0;
    cfg_index = REG_RESERVED;
    cfg_data = '0;
    foreach (m_bitmap[i]) begin
      m_bitmap[i] = 1'b0;
      m_link[i] = 0;
    end
    m_head = MAX_PAGES;
    m_free = 0;
    m_total = 0;
    m_reserved = 3;
    m_existing = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_stale_head();
    test_config_extremes();
    test_random(300, 3, 0);
    test_random(300, 20, 180);
    test_random(300, 1, 64);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bep_pkg.sv
rtl/core/bep_ram.sv
rtl/core/bitmap_extent_page_allocator.sv
test/tb_bitmap_extent_page_allocator.sv
